// ===== design/atcl_pkg.sv =====
// atcl_pkg: constants, codes and shared types of the AT command line parser.
// No dependencies; the modules of the block and the bench import it, the interfaces do not.

package atcl_pkg;

    localparam int MAX_ARGS     = 8;
    localparam int MAX_NAME_LEN = 16;
    localparam int MAX_LINE_LEN = 256;

    localparam int NCMDS       = 8;
    localparam int CMD_CHARS   = 9;
    localparam int QUEUE_DEPTH = 4;

    localparam int POS_W      = 8;
    localparam int NAME_LEN_W = $clog2(MAX_NAME_LEN + 1);
    localparam int NARG_W     = $clog2(MAX_ARGS + 1);

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_T = 8'h74;

    typedef enum logic [2:0] {
        PH_PREFIX_A = 3'd0,
        PH_PREFIX_T = 3'd1,
        PH_NAME     = 3'd2,
        PH_QUERY    = 3'd3,
        PH_EQ       = 3'd4,
        PH_ARGS     = 3'd5,
        PH_SKIPWS   = 3'd6,
        PH_IDLE     = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        MODE_READ   = 3'd0,
        MODE_HELP   = 3'd1,
        MODE_SET    = 3'd2,
        MODE_ACTIVE = 3'd3,
        MODE_BAD    = 3'd4
    } t_mode;

    // names right-justified in CMD_CHARS bytes, first character highest
    localparam logic [8*CMD_CHARS-1:0] CMD_NAME [NCMDS] = '{
        "$reboot", "$shutdown", "$catch", "$isink",
        "$adorecd", "$vdorecd", "$capture", "$time"
    };
    localparam int unsigned CMD_LEN [NCMDS] = '{7, 9, 6, 6, 8, 8, 8, 5};

    // everything one byte causes: an optional argument record and an optional verdict
    typedef struct packed {
        logic       rec_v;
        logic [2:0] rec_num;
        logic [7:0] rec_off;
        logic [7:0] rec_len;
        logic       ver_v;
        logic       known;
        logic [2:0] cmd_idx;
        t_mode      mode;
        logic [3:0] count;
        logic       status;
    } t_bundle;

endpackage

// ===== design/atcl_in_if.sv =====
// atcl_in_if: input byte channel of the AT command line parser.
// Valid/ready handshake with the line byte and end-of-line flag; no dependencies.

interface atcl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       end_of_line;

    modport source (output valid, output line_byte, output end_of_line, input ready);
    modport sink   (input valid, input line_byte, input end_of_line, output ready);
endinterface

// ===== design/atcl_out_if.sv =====
// atcl_out_if: result channel of the AT command line parser.
// Valid/ready handshake carrying argument records and line verdicts; no dependencies.

interface atcl_out_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [2:0] arg_number;
    logic [7:0] arg_offset;
    logic [7:0] arg_length;
    logic       is_known_command;
    logic [2:0] command_index;
    logic [2:0] exec_mode;
    logic [3:0] arg_count;
    logic       verdict_status;
    logic       last_of_run;

    modport source (
        output valid, output item_kind, output arg_number, output arg_offset,
        output arg_length, output is_known_command, output command_index,
        output exec_mode, output arg_count, output verdict_status, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input item_kind, input arg_number, input arg_offset,
        input arg_length, input is_known_command, input command_index,
        input exec_mode, input arg_count, input verdict_status, input last_of_run,
        output ready
    );
endinterface

// ===== design/atcl_front.sv =====
// atcl_front: accepts line bytes, tracks prefix, name, mode and arguments.
// Pushes one bundle per byte that causes results. Depends on atcl_pkg, atcl_in_if.

module atcl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    atcl_in_if.sink           i_in,
    input  logic              i_full,
    output logic              o_push,
    output atcl_pkg::t_bundle o_bundle
);
    import atcl_pkg::*;

    typedef struct packed {
        t_phase            phase;
        logic              in_arg;
        logic              in_quote;
        logic [7:0]        start;
        logic [7:0]        len;
        logic [NARG_W-1:0] nargs;
    } t_arg_st;

    typedef struct packed {
        t_arg_st    st;
        logic       rec_v;
        logic [2:0] rec_num;
        logic [7:0] rec_off;
        logic [7:0] rec_len;
    } t_arg_res;

    typedef struct packed {
        logic       found;
        logic [2:0] idx;
    } t_match;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] cmd_char(input int i, input logic [NAME_LEN_W-1:0] k);
        logic [7:0] ch;
        int         base;
        ch   = '0;
        base = 0;
        if (int'(k) < int'(CMD_LEN[i])) begin
            base = 8 * (int'(CMD_LEN[i]) - 1 - int'(k));
            ch   = CMD_NAME[i][base +: 8];
        end
        return ch;
    endfunction

    // lowest table entry still matching with the exact length
    function automatic t_match match_cmd(input logic [NCMDS-1:0] mask,
                                         input logic [NAME_LEN_W-1:0] nlen);
        t_match m;
        m = '0;
        for (int i = NCMDS - 1; i >= 0; i--) begin
            if (mask[i] && int'(nlen) == int'(CMD_LEN[i])) begin
                m.found = 1'b1;
                m.idx   = 3'(i);
            end
        end
        return m;
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic in_args(input t_phase ph);
        return (ph == PH_ARGS) || (ph == PH_SKIPWS);
    endfunction

    function automatic t_arg_res put_arg(input t_arg_st s);
        t_arg_res r;
        r.st       = s;
        r.rec_v    = 1'b1;
        r.rec_num  = 3'(s.nargs);
        r.rec_off  = s.start;
        r.rec_len  = s.len;
        r.st.nargs = s.nargs + NARG_W'(1);
        r.st.in_arg = 1'b0;
        if (r.st.nargs >= NARG_W'(MAX_ARGS)) begin
            r.st.phase = PH_IDLE;
        end
        return r;
    endfunction

    function automatic t_arg_res arg_byte(input t_arg_st s, input logic [7:0] c,
                                          input logic [7:0] o);
        t_arg_res r;
        logic     skip;
        r      = '0;
        r.st   = s;
        skip   = 1'b0;
        if (r.st.phase == PH_SKIPWS) begin
            if (is_space(c)) skip = 1'b1;
            else             r.st.phase = PH_ARGS;
        end
        if (!skip && !r.st.in_arg) begin
            if (is_space(c)) begin
                skip = 1'b1;
            end else begin
                r.st.in_arg = 1'b1;
                r.st.start  = o;
                r.st.len    = '0;
            end
        end
        if (!skip) begin
            if (r.st.in_quote && c != CH_QUOTE) begin
                r.st.len = sat_inc(r.st.len);
            end else if (c == CH_COMMA) begin
                r = put_arg(r.st);
            end else if (c == CH_QUOTE) begin
                if (!r.st.in_quote) begin
                    // opening quote: argument starts after it
                    r.st.start    = r.st.start + 8'd1;
                    r.st.in_quote = 1'b1;
                end else begin
                    r.st.in_quote = 1'b0;
                    r.st.phase    = PH_SKIPWS;
                end
            end else if (c != CH_CR && c != CH_LF && c != CH_SPACE) begin
                r.st.len = sat_inc(r.st.len);
            end
        end
        return r;
    endfunction

    t_arg_st               r_arg, n_arg;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [NAME_LEN_W-1:0] r_name_len, n_name_len;
    logic [NCMDS-1:0]      r_mask, n_mask;
    t_mode                 r_mode, n_mode;
    logic                  r_look, n_look;
    logic                  r_too_long, n_too_long;

    logic       w_accept;
    logic       w_eol;
    logic       w_rec_v;
    logic [2:0] w_rec_num;
    logic [7:0] w_rec_off;
    logic [7:0] w_rec_len;
    logic       w_known;
    logic [2:0] w_idx;
    t_mode      w_vmode;
    logic [3:0] w_count;
    logic       w_status;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_eol      = i_in.end_of_line;

    // next state
    always_comb begin
        t_arg_res   ar;
        t_match     m_cur;
        t_match     m_new;
        logic [7:0] c;
        logic [7:0] lc;
        c          = i_in.line_byte;
        lc         = to_lower(c);
        ar         = '0;
        m_cur      = match_cmd(r_mask, r_name_len);
        m_new      = '0;
        n_arg      = r_arg;
        n_pos      = r_pos;
        n_name_len = r_name_len;
        n_mask     = r_mask;
        n_mode     = r_mode;
        n_look     = r_look;
        n_too_long = r_too_long;
        w_rec_v    = 1'b0;
        w_rec_num  = '0;
        w_rec_off  = '0;
        w_rec_len  = '0;
        w_known    = 1'b0;
        w_idx      = '0;
        w_vmode    = MODE_BAD;
        w_count    = '0;
        w_status   = 1'b0;

        if (r_too_long) begin
            n_arg.phase    = PH_IDLE;
            n_mode         = MODE_BAD;
            n_arg.in_arg   = 1'b0;
            n_arg.in_quote = 1'b0;
        end else begin
            unique case (r_arg.phase)
                PH_PREFIX_A: begin
                    if (lc == CH_LOWER_A) begin
                        n_arg.phase = PH_PREFIX_T;
                    end else begin
                        n_mode      = MODE_BAD;
                        n_arg.phase = PH_IDLE;
                    end
                end
                PH_PREFIX_T: begin
                    if (lc == CH_LOWER_T) begin
                        n_arg.phase = PH_NAME;
                    end else begin
                        n_mode      = MODE_BAD;
                        n_arg.phase = PH_IDLE;
                    end
                end
                PH_NAME: begin
                    if (r_name_len >= NAME_LEN_W'(MAX_NAME_LEN)) begin
                        n_mode      = MODE_BAD;
                        n_arg.phase = PH_IDLE;
                    end else if (c == CH_QMARK) begin
                        if (w_eol) begin
                            n_mode      = MODE_BAD;
                            n_arg.phase = PH_IDLE;
                        end else begin
                            n_arg.phase = PH_QUERY;
                        end
                    end else if (c == CH_EQUALS) begin
                        if (w_eol) begin
                            n_mode      = MODE_BAD;
                            n_arg.phase = PH_IDLE;
                        end else begin
                            n_arg.phase = PH_EQ;
                            n_look      = 1'b0;
                        end
                    end else if (c == CH_CR || c == CH_LF) begin
                        n_arg.phase = PH_IDLE;
                        n_mode      = w_eol ? MODE_ACTIVE : MODE_BAD;
                    end else begin
                        for (int i = 0; i < NCMDS; i++) begin
                            if (int'(r_name_len) >= int'(CMD_LEN[i]) ||
                                cmd_char(i, r_name_len) != lc) begin
                                n_mask[i] = 1'b0;
                            end
                        end
                        n_name_len = r_name_len + NAME_LEN_W'(1);
                    end
                end
                PH_QUERY: begin
                    n_arg.phase = PH_IDLE;
                    n_mode      = (c == CH_CR && w_eol) ? MODE_READ : MODE_BAD;
                end
                PH_EQ: begin
                    if (!r_look) begin
                        if (c == CH_CR || c == CH_LF) begin
                            n_mode      = MODE_BAD;
                            n_arg.phase = PH_IDLE;
                        end else if (c == CH_QMARK && !w_eol) begin
                            n_look = 1'b1;
                        end else begin
                            n_mode      = MODE_SET;
                            n_arg.phase = m_cur.found ? PH_ARGS : PH_IDLE;
                            if (m_cur.found) begin
                                ar    = arg_byte(n_arg, c, r_pos);
                                n_arg = ar.st;
                            end
                        end
                    end else begin
                        n_look = 1'b0;
                        if (c == CH_CR && w_eol) begin
                            n_mode      = MODE_HELP;
                            n_arg.phase = PH_IDLE;
                        end else begin
                            n_mode      = MODE_SET;
                            n_arg.phase = m_cur.found ? PH_ARGS : PH_IDLE;
                            if (m_cur.found) begin
                                // held question mark goes in at its own offset
                                ar    = arg_byte(n_arg, CH_QMARK, r_pos - 8'd1);
                                n_arg = ar.st;
                                if (in_args(n_arg.phase)) begin
                                    ar    = arg_byte(n_arg, c, r_pos);
                                    n_arg = ar.st;
                                end
                            end
                        end
                    end
                end
                PH_ARGS, PH_SKIPWS: begin
                    ar    = arg_byte(n_arg, c, r_pos);
                    n_arg = ar.st;
                end
                PH_IDLE: begin
                end
                default: begin
                end
            endcase
            if (ar.rec_v) begin
                w_rec_v   = 1'b1;
                w_rec_num = ar.rec_num;
                w_rec_off = ar.rec_off;
                w_rec_len = ar.rec_len;
            end
            if (r_pos >= POS_W'(MAX_LINE_LEN - 1)) n_too_long = 1'b1;
            else                                  n_pos      = r_pos + POS_W'(1);
        end

        if (w_eol) begin
            if (in_args(n_arg.phase) && n_arg.in_arg) begin
                ar        = put_arg(n_arg);
                n_arg     = ar.st;
                w_rec_v   = 1'b1;
                w_rec_num = ar.rec_num;
                w_rec_off = ar.rec_off;
                w_rec_len = ar.rec_len;
            end
            m_new    = match_cmd(n_mask, n_name_len);
            w_known  = (n_mode != MODE_BAD) && m_new.found;
            w_idx    = w_known ? m_new.idx : 3'd0;
            w_vmode  = n_mode;
            w_count  = (w_known && n_mode == MODE_SET && !n_arg.in_quote) ?
                       4'(n_arg.nargs) : 4'd0;
            w_status = w_known && (n_mode == MODE_SET) && (w_count == 4'd0);

            n_arg.phase    = PH_PREFIX_A;
            n_arg.in_arg   = 1'b0;
            n_arg.in_quote = 1'b0;
            n_arg.start    = '0;
            n_arg.len      = '0;
            n_arg.nargs    = '0;
            n_pos          = '0;
            n_name_len     = '0;
            n_mask         = '1;
            n_mode         = MODE_BAD;
            n_look         = 1'b0;
            n_too_long     = 1'b0;
        end
    end

    // outputs
    always_comb begin
        o_push           = w_accept && (w_rec_v || w_eol);
        o_bundle.rec_v   = w_rec_v;
        o_bundle.rec_num = w_rec_num;
        o_bundle.rec_off = w_rec_off;
        o_bundle.rec_len = w_rec_len;
        o_bundle.ver_v   = w_eol;
        o_bundle.known   = w_known;
        o_bundle.cmd_idx = w_idx;
        o_bundle.mode    = w_vmode;
        o_bundle.count   = w_count;
        o_bundle.status  = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arg.phase    <= PH_PREFIX_A;
            r_arg.in_arg   <= 1'b0;
            r_arg.in_quote <= 1'b0;
            r_arg.start    <= '0;
            r_arg.len      <= '0;
            r_arg.nargs    <= '0;
            r_pos          <= '0;
            r_name_len     <= '0;
            r_mask         <= '1;
            r_mode         <= MODE_BAD;
            r_look         <= 1'b0;
            r_too_long     <= 1'b0;
        end else if (w_accept) begin
            r_arg      <= n_arg;
            r_pos      <= n_pos;
            r_name_len <= n_name_len;
            r_mask     <= n_mask;
            r_mode     <= n_mode;
            r_look     <= n_look;
            r_too_long <= n_too_long;
        end
    end

endmodule

// ===== design/atcl_queue.sv =====
// atcl_queue: short FIFO of result bundles between front and back end.
// Register array with read and write pointers. Depends on atcl_pkg.

module atcl_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  atcl_pkg::t_bundle i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output atcl_pkg::t_bundle o_data
);
    import atcl_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    t_bundle          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop)      n_count = r_count + CNT_W'(1);
        else if (!i_push && i_pop) n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== design/atcl_back.sv =====
// atcl_back: unpacks queued bundles into single results on the output channel.
// Record first, then the verdict of the same byte. Depends on atcl_pkg, atcl_out_if.

module atcl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  atcl_pkg::t_bundle i_data,
    output logic              o_pop,
    atcl_out_if.source        o_out
);
    import atcl_pkg::*;

    typedef struct packed {
        logic       item_kind;
        logic [2:0] arg_number;
        logic [7:0] arg_offset;
        logic [7:0] arg_length;
        logic       is_known_command;
        logic [2:0] command_index;
        logic [2:0] exec_mode;
        logic [3:0] arg_count;
        logic       verdict_status;
        logic       last_of_run;
    } t_result;

    function automatic t_result mk_rec(input t_bundle b);
        t_result r;
        r            = '0;
        r.arg_number = b.rec_num;
        r.arg_offset = b.rec_off;
        r.arg_length = b.rec_len;
        r.last_of_run = !b.ver_v;
        return r;
    endfunction

    function automatic t_result mk_ver(input t_bundle b);
        t_result r;
        r                  = '0;
        r.item_kind        = 1'b1;
        r.is_known_command = b.known;
        r.command_index    = b.cmd_idx;
        r.exec_mode        = 3'(b.mode);
        r.arg_count        = b.count;
        r.verdict_status   = b.status;
        r.last_of_run      = 1'b1;
        return r;
    endfunction

    logic    r_valid, n_valid;
    logic    r_pend, n_pend;
    t_result r_res, n_res;
    t_result r_held, n_held;
    logic    w_load;

    assign w_load = !r_valid || o_out.ready;
    assign o_pop  = w_load && !r_pend && !i_empty;

    always_comb begin
        n_valid = r_valid;
        n_pend  = r_pend;
        n_res   = r_res;
        n_held  = r_held;
        if (w_load) begin
            if (r_pend) begin
                n_res   = r_held;
                n_valid = 1'b1;
                n_pend  = 1'b0;
            end else if (!i_empty) begin
                n_valid = 1'b1;
                if (i_data.rec_v) begin
                    n_res  = mk_rec(i_data);
                    n_held = mk_ver(i_data);
                    n_pend = i_data.ver_v;
                end else begin
                    n_res = mk_ver(i_data);
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_held <= n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.item_kind        = r_res.item_kind;
    assign o_out.arg_number       = r_res.arg_number;
    assign o_out.arg_offset       = r_res.arg_offset;
    assign o_out.arg_length       = r_res.arg_length;
    assign o_out.is_known_command = r_res.is_known_command;
    assign o_out.command_index    = r_res.command_index;
    assign o_out.exec_mode        = r_res.exec_mode;
    assign o_out.arg_count        = r_res.arg_count;
    assign o_out.verdict_status   = r_res.verdict_status;
    assign o_out.last_of_run      = r_res.last_of_run;

endmodule

// ===== design/at_command_line_parser.sv =====
// at_command_line_parser: top level; front end, result queue and back end.
// Depends on atcl_pkg, atcl_in_if, atcl_out_if, atcl_front, atcl_queue, atcl_back.
//
//  port    | dir | carries                                  | accepted when
//  --------+-----+------------------------------------------+-------------------
//  i_in    | in  | line_byte, end_of_line                   | valid && ready
//  o_out   | out | argument record or line verdict          | valid && ready
//
// One byte is taken per cycle; the front end updates the line state in the
// cycle it accepts a byte. A byte that ends an argument and the line yields two
// results, which leave the output register one after the other. The
// four-entry queue lets the front end run while the output is stalled;
// ready drops only when the queue is full. Reset is synchronous and active low.

module at_command_line_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    atcl_in_if.sink    i_in,
    atcl_out_if.source o_out
);
    import atcl_pkg::*;

    t_bundle w_push_data;
    t_bundle w_pop_data;
    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;

    atcl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_bundle (w_push_data)
    );

    atcl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_pop_data)
    );

    atcl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_data  (w_pop_data),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ===== sim/at_command_line_parser_test.sv =====
`timescale 1ns / 1ps
// at_command_line_parser_test: self-checking bench for the AT command line parser.
// Needs atcl_pkg, atcl_in_if, atcl_out_if and the parser RTL; reads nothing else.

module at_command_line_parser_test;
    import atcl_pkg::*;

    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LOWER_B = 8'h62;

    typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} t_rx_style;

    typedef struct {
        logic [7:0] ch;
        logic       eol;
        bit         hold;   // wait for every report of earlier lines first
    } t_line_byte;

    typedef struct packed {
        logic       kind;
        logic [2:0] num;
        logic [7:0] off;
        logic [7:0] len;
        logic       known;
        logic [2:0] idx;
        logic [2:0] mode;
        logic [3:0] count;
        logic       status;
        logic       last;
    } t_report;

    logic i_clk;
    logic i_rst_n;

    atcl_in_if  req_ch ();
    atcl_out_if res_ch ();

    at_command_line_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    string cmd_text [NCMDS] = '{
        "$reboot", "$shutdown", "$catch", "$isink",
        "$adorecd", "$vdorecd", "$capture", "$time"
    };
    string plain_set = "0123456789abcdefXYZ-+.;:/";

    // line state of the parser model
    int         pos;
    t_phase     phase;
    int         nlen;
    logic [7:0] mask;
    t_mode      mode;
    bit         held_q;
    bit         in_arg;
    bit         in_quote;
    bit         overflow;
    logic [7:0] a_start;
    logic [7:0] a_len;
    int         n_args;
    t_report    step_out [2];
    int         n_out;

    logic [7:0] lbuf [$];
    t_line_byte bytes_due [$];
    t_report    reports_due [$];

    int fails = 0;
    int lines_planned = 0;
    int bytes_planned = 0;
    int n_records = 0;
    int n_verdicts = 0;
    int n_known = 0;
    int mode_tally [5] = '{0, 0, 0, 0, 0};

    bit        took = 0;
    int        burst_left = 8;
    int        gap_left = 0;
    int        stall_tick = 0;
    t_rx_style stall_style = RX_OPEN;

    function automatic void clear_line();
        pos      = 0;
        phase    = PH_PREFIX_A;
        nlen     = 0;
        mask     = 8'hFF;
        mode     = MODE_BAD;
        held_q   = 0;
        in_arg   = 0;
        in_quote = 0;
        a_start  = 8'd0;
        a_len    = 8'd0;
        n_args   = 0;
        overflow = 0;
    endfunction

    function automatic void abort_line();
        mode  = MODE_BAD;
        phase = PH_IDLE;
    endfunction

    function automatic bit is_ws(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] fold(logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + 8'd32 : c;
    endfunction

    function automatic int cmd_hit();
        int i;
        for (i = 0; i < NCMDS; i++)
            if (mask[i] && nlen == cmd_text[i].len())
                return i;
        return -1;
    endfunction

    function automatic bit in_arg_phase();
        return phase == PH_ARGS || phase == PH_SKIPWS;
    endfunction

    function automatic void count_char();
        if (a_len != 8'hFF)
            a_len = a_len + 8'd1;
    endfunction

    function automatic void close_arg();
        if (n_out >= 2)
            return;
        step_out[n_out]     = '0;
        step_out[n_out].num = n_args[2:0];
        step_out[n_out].off = a_start;
        step_out[n_out].len = a_len;
        n_out++;
        n_args++;
        in_arg = 0;
        if (n_args >= MAX_ARGS)
            phase = PH_IDLE;
    endfunction

    function automatic void arg_char(logic [7:0] c, logic [7:0] o);
        if (phase == PH_SKIPWS) begin
            if (is_ws(c))
                return;
            phase = PH_ARGS;
        end
        if (!in_arg) begin
            if (is_ws(c))
                return;
            in_arg  = 1;
            a_start = o;
            a_len   = 8'd0;
        end
        if (in_quote && c != CH_QUOTE) begin
            count_char();
            return;
        end
        if (c == CH_COMMA) begin
            close_arg();
        end else if (c == CH_QUOTE) begin
            if (!in_quote) begin
                a_start  = a_start + 8'd1;
                in_quote = 1;
            end else begin
                in_quote = 0;
                phase    = PH_SKIPWS;
            end
        end else if (c != CH_CR && c != CH_LF && c != CH_SPACE) begin
            count_char();
        end
    endfunction

    function automatic void start_set();
        mode  = MODE_SET;
        phase = (cmd_hit() >= 0) ? PH_ARGS : PH_IDLE;
    endfunction

    // one accepted byte: update the line state and queue the reports it causes
    function automatic void parse_byte(logic [7:0] c, logic eol);
        logic [7:0] o;
        int         hit;
        bit         known;
        logic [3:0] cnt;
        t_report    v;
        int         i;
        o     = pos[7:0];
        n_out = 0;
        if (overflow) begin
            abort_line();
            in_arg   = 0;
            in_quote = 0;
        end else begin
            case (phase)
                PH_PREFIX_A: begin
                    if (fold(c) == CH_LOWER_A) phase = PH_PREFIX_T; else abort_line();
                end
                PH_PREFIX_T: begin
                    if (fold(c) == CH_LOWER_T) phase = PH_NAME; else abort_line();
                end
                PH_NAME: begin
                    if (nlen >= MAX_NAME_LEN) begin
                        abort_line();
                    end else if (c == CH_QMARK) begin
                        if (eol) abort_line(); else phase = PH_QUERY;
                    end else if (c == CH_EQUALS) begin
                        if (eol) begin
                            abort_line();
                        end else begin
                            phase  = PH_EQ;
                            held_q = 0;
                        end
                    end else if (c == CH_CR || c == CH_LF) begin
                        if (eol) begin
                            mode  = MODE_ACTIVE;
                            phase = PH_IDLE;
                        end else begin
                            abort_line();
                        end
                    end else begin
                        for (i = 0; i < NCMDS; i++) begin
                            if (nlen >= cmd_text[i].len())
                                mask[i] = 1'b0;
                            else if (cmd_text[i][nlen] != fold(c))
                                mask[i] = 1'b0;
                        end
                        nlen++;
                    end
                end
                PH_QUERY: begin
                    if (c == CH_CR && eol) begin
                        mode  = MODE_READ;
                        phase = PH_IDLE;
                    end else begin
                        abort_line();
                    end
                end
                PH_EQ: begin
                    if (!held_q) begin
                        if (c == CH_CR || c == CH_LF) begin
                            abort_line();
                        end else if (c == CH_QMARK && !eol) begin
                            held_q = 1;
                        end else begin
                            start_set();
                            if (in_arg_phase()) arg_char(c, o);
                        end
                    end else begin
                        held_q = 0;
                        if (c == CH_CR && eol) begin
                            mode  = MODE_HELP;
                            phase = PH_IDLE;
                        end else begin
                            // the held '?' belongs to the first argument, one byte back
                            start_set();
                            if (in_arg_phase()) arg_char(CH_QMARK, o - 8'd1);
                            if (in_arg_phase()) arg_char(c, o);
                        end
                    end
                end
                PH_ARGS, PH_SKIPWS: arg_char(c, o);
                default: ;
            endcase
            if (pos >= MAX_LINE_LEN - 1)
                overflow = 1;
            else
                pos++;
        end

        if (eol) begin
            if (in_arg_phase() && in_arg)
                close_arg();
            hit   = cmd_hit();
            known = mode != MODE_BAD && hit >= 0;
            cnt   = (known && mode == MODE_SET && !in_quote) ? n_args[3:0] : 4'd0;
            if (n_out < 2) begin
                v        = '0;
                v.kind   = 1'b1;
                v.known  = known;
                v.idx    = known ? hit[2:0] : 3'd0;
                v.mode   = mode;
                v.count  = cnt;
                v.status = known && mode == MODE_SET && cnt == 4'd0;
                step_out[n_out] = v;
                n_out++;
            end
            clear_line();
        end

        if (n_out > 0)
            step_out[n_out - 1].last = 1'b1;
        for (i = 0; i < n_out; i++)
            reports_due.push_back(step_out[i]);
    endfunction

    // ---- line building ----

    function automatic void put_text(string s, bit mixcase);
        logic [7:0] b;
        int         i;
        for (i = 0; i < s.len(); i++) begin
            b = s[i];
            if (mixcase && fold(b) >= CH_LOWER_A && fold(b) <= CH_LOWER_Z
                    && $urandom_range(0, 1) == 1)
                b = b ^ 8'h20;
            lbuf.push_back(b);
        end
    endfunction

    function automatic void commit_line(bit hold);
        t_line_byte e;
        int         i;
        if (lbuf.size() == 0)
            lbuf.push_back(8'($urandom_range(0, 255)));
        for (i = 0; i < lbuf.size(); i++) begin
            e.ch   = lbuf[i];
            e.eol  = (i == lbuf.size() - 1);
            e.hold = hold && i == 0;
            bytes_due.push_back(e);
        end
        bytes_planned += lbuf.size();
        lines_planned++;
        lbuf.delete();
    endfunction

    function automatic void fill_chars(int n, bit quoted);
        int         i;
        int         r;
        logic [7:0] b;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 15);
            if (r == 0) begin
                b = CH_SPACE;
            end else if (r == 1) begin
                do b = 8'($urandom_range(0, 255));
                while (b == CH_COMMA || b == CH_QUOTE);
            end else if (r == 2 && quoted) begin
                b = CH_COMMA;
            end else begin
                b = plain_set[$urandom_range(0, plain_set.len() - 1)];
            end
            lbuf.push_back(b);
        end
    endfunction

    function automatic void random_args();
        int n;
        int k;
        int r;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 11) : $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
            if (k > 0)
                lbuf.push_back(CH_COMMA);
            else if ($urandom_range(0, 7) == 0)
                lbuf.push_back(CH_QMARK);
            if ($urandom_range(0, 3) == 0)
                lbuf.push_back($urandom_range(0, 2) == 0 ? CH_SPACE
                                                        : 8'($urandom_range(CH_TAB, CH_CR)));
            r = $urandom_range(0, 99);
            if (r < 50) begin
                fill_chars($urandom_range(0, 6), 0);
            end else if (r < 85) begin
                lbuf.push_back(CH_QUOTE);
                fill_chars($urandom_range(0, 6), 1);
                lbuf.push_back(CH_QUOTE);
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3)) lbuf.push_back(CH_SPACE);
            end else if (r < 92) begin
                lbuf.push_back(CH_QUOTE);           // left open
                fill_chars($urandom_range(0, 5), 1);
            end else begin
                fill_chars($urandom_range(1, 3), 0);
                lbuf.push_back(CH_QUOTE);
                fill_chars($urandom_range(1, 3), 1);
                lbuf.push_back(CH_QUOTE);
                fill_chars($urandom_range(0, 2), 0);
            end
        end
        r = $urandom_range(0, 99);
        if (r < 60)
            lbuf.push_back(CH_CR);
        else if (r < 75)
            lbuf.push_back(CH_LF);
    endfunction

    function automatic void long_line(bit hold, int total);
        put_text("AT", 1);
        put_text(cmd_text[$urandom_range(0, NCMDS - 1)], 1);
        lbuf.push_back(CH_EQUALS);
        while (lbuf.size() < total - 1) begin
            if ($urandom_range(0, 19) == 0)
                lbuf.push_back(CH_COMMA);
            else
                fill_chars(1, 0);
        end
        lbuf.push_back(CH_CR);
        commit_line(hold);
    endfunction

    function automatic void random_line(bit hold);
        int    r;
        int    k;
        string nm;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 12)) lbuf.push_back(8'($urandom_range(0, 255)));
            commit_line(hold);
            return;
        end

        r = $urandom_range(0, 99);
        if (r < 94)
            put_text("AT", 1);
        else if (r < 97)
            put_text("A", 1);
        else
            repeat (2) lbuf.push_back(8'($urandom_range(0, 255)));

        r  = $urandom_range(0, 99);
        nm = cmd_text[$urandom_range(0, NCMDS - 1)];
        if (r < 70) begin
            put_text(nm, 1);
        end else if (r < 78) begin
            put_text(nm.substr(0, nm.len() - 2), 1);
        end else if (r < 84) begin
            put_text(nm, 1);
            put_text("x", 1);
        end else if (r < 92) begin
            put_text("$", 0);
            repeat ($urandom_range(1, 9))
                lbuf.push_back(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
        end else if (r < 97) begin
            // names either side of the length limit
            repeat ($urandom_range(15, 20))
                lbuf.push_back(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
        end

        r = $urandom_range(0, 99);
        if (r < 14) begin
            lbuf.push_back(CH_QMARK);
            if ($urandom_range(0, 9) == 0)
                lbuf.push_back(8'($urandom_range(0, 255)));
            lbuf.push_back(CH_CR);
        end else if (r < 26) begin
            lbuf.push_back(CH_EQUALS);
            lbuf.push_back(CH_QMARK);
            lbuf.push_back(($urandom_range(0, 9) == 0) ? CH_LF : CH_CR);
        end else if (r < 38) begin
            if ($urandom_range(0, 9) == 0)
                lbuf.push_back(CH_CR);
            lbuf.push_back(($urandom_range(0, 1) == 1) ? CH_CR : CH_LF);
        end else if (r < 94) begin
            lbuf.push_back(CH_EQUALS);
            random_args();
        end else begin
            repeat ($urandom_range(1, 3)) lbuf.push_back(8'($urandom_range(0, 255)));
        end

        r = $urandom_range(0, 99);
        if (r < 5) begin
            lbuf[$urandom_range(0, lbuf.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (r < 8 && lbuf.size() > 1) begin
            k = $urandom_range(1, lbuf.size() - 1);
            while (lbuf.size() > k)
                void'(lbuf.pop_back());
        end
        commit_line(hold);
    endfunction

    function automatic void chk(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            fails++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endfunction

    // ---- clock, driver, receiver, checker ----

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        bit was_taken;
        bit go;
        was_taken = took;
        took      = 0;
        if (was_taken) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
        if (!i_rst_n) begin
            go = 0;
        end else if (req_ch.valid && !was_taken) begin
            go = 1;                 // a request stays up until it is taken
        end else if (gap_left > 0) begin
            gap_left--;
            go = 0;
        end else begin
            go = bytes_due.size() > 0 && !(bytes_due[0].hold && reports_due.size() > 0);
        end
        req_ch.valid <= go;
        if (go) begin
            req_ch.line_byte   <= bytes_due[0].ch;
            req_ch.end_of_line <= bytes_due[0].eol;
        end
    end

    always @(negedge i_clk) begin
        stall_tick++;
        if (stall_tick % 96 == 0)
            stall_style = t_rx_style'($urandom_range(0, 3));
        case (stall_style)
            RX_OPEN:     res_ch.ready <= 1'b1;
            RX_COIN:     res_ch.ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: res_ch.ready <= (stall_tick % 7) < 4;
            default:     res_ch.ready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            parse_byte(bytes_due[0].ch, bytes_due[0].eol);
            void'(bytes_due.pop_front());
            took = 1;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.item_kind, res_ch.arg_number, res_ch.arg_offset, res_ch.arg_length,
                   res_ch.is_known_command, res_ch.command_index, res_ch.exec_mode,
                   res_ch.arg_count, res_ch.verdict_status, res_ch.last_of_run};
            if (reports_due.size() == 0) begin
                fails++;
                $display("%0t: report with none due, expected nothing actual %h", $time, got);
            end else begin
                want = reports_due.pop_front();
                chk("item_kind", want.kind, got.kind);
                chk("arg_number", want.num, got.num);
                chk("arg_offset", want.off, got.off);
                chk("arg_length", want.len, got.len);
                chk("is_known_command", want.known, got.known);
                chk("command_index", want.idx, got.idx);
                chk("exec_mode", want.mode, got.mode);
                chk("arg_count", want.count, got.count);
                chk("verdict_status", want.status, got.status);
                chk("last_of_run", want.last, got.last);
                if (want.kind) begin
                    n_verdicts++;
                    n_known += want.known;
                    mode_tally[want.mode]++;
                end else begin
                    n_records++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("at_command_line_parser_test failed");
        $finish;
    end

    initial begin
        bit first;
        req_ch.valid       = 1'b0;
        req_ch.line_byte   = 8'd0;
        req_ch.end_of_line = 1'b0;
        res_ch.ready       = 1'b0;
        i_rst_n            = 1'b0;
        clear_line();

        // directed lines
        put_text("AT$reboot?", 0);               lbuf.push_back(CH_CR); commit_line(0);
        put_text("at$SHUTDOWN=?", 0);            lbuf.push_back(CH_CR); commit_line(0);
        put_text("At$catch", 0);                 lbuf.push_back(CH_CR); commit_line(0);
        put_text("aT$iSiNk", 0);                 lbuf.push_back(CH_LF); commit_line(0);
        put_text("AT$adorecd=1,\"a,b\", x y ,", 0); lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$vdorecd=\"open", 0);        lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$capture=?5,6", 0);          lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$time=a,b,c,d,e,f,g,h,i,j", 0); lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$foo=1,2", 0);               lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$foo?", 0);                  lbuf.push_back(CH_CR); commit_line(0);
        put_text("XT$time?", 0);                 lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$abcdefghijklmnopq?", 0);    lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$time=", 0);                 lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$time", 0); lbuf.push_back(8'h00); put_text("=1", 0);
        lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$time=1", 0); lbuf.push_back(8'h00); put_text(",2", 0);
        lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$time?x", 0);                lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$time=?", 0);                commit_line(0);
        put_text("A", 0);                        commit_line(0);
        put_text("AT$time=,,", 0);               lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$time= ", 0); lbuf.push_back(CH_TAB); lbuf.push_back(CH_VT);
        lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$time=a\"b\"c", 0);          lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$time= \"x\"  ,y", 0);       lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT", 0); lbuf.push_back(8'hFF); lbuf.push_back(8'h80);
        put_text("?", 0); lbuf.push_back(CH_CR); commit_line(0);
        put_text("AT$time=x", 0);                commit_line(0);
        // full-length line: last argument starts on the final offset
        put_text("AT$time=", 0);
        repeat (246) lbuf.push_back(CH_LOWER_A);
        lbuf.push_back(CH_COMMA); lbuf.push_back(CH_LOWER_B);
        commit_line(0);
        long_line(0, 262);

        // random lines, mostly well formed, until at least 950 bytes are planned in all
        first = 1;
        do begin
            if ($urandom_range(0, 79) == 0)
                long_line(first, $urandom_range(250, 266));
            else
                random_line(first || $urandom_range(0, 14) == 0);
            first = 0;
        end while (bytes_planned < 950);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_due.size() != 0 || reports_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Parsed %0d bytes in %0d lines; %0d argument records",
                 bytes_planned, lines_planned, n_records);
        $display("and %0d verdicts (%0d known): read %0d, help %0d, set %0d, active %0d, bad %0d.",
                 n_verdicts, n_known, mode_tally[MODE_READ], mode_tally[MODE_HELP],
                 mode_tally[MODE_SET], mode_tally[MODE_ACTIVE], mode_tally[MODE_BAD]);
        if (fails == 0)
            $display("at_command_line_parser_test passed");
        else
            $display("at_command_line_parser_test failed");
        $finish;
    end

endmodule
